/* rtl/dpp_pkg.sv */
// Shared types, register codes and pipeline constants for the depth point projection.
// Used by every design module of the block; depends on nothing.
package dpp_pkg;

    // Register indexes on the write port
    localparam logic [2:0] REG_FOCAL_X      = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [2:0] REG_CENTER_X     = 3'd2;
    localparam logic [2:0] REG_CENTER_Y     = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

    // Reset values of the registers
    localparam logic [23:0] FOCAL_RST  = 24'd65536;
    localparam logic [23:0] CENTER_RST = 24'd0;
    localparam logic [11:0] WIDTH_RST  = 12'd320;
    localparam logic [11:0] HEIGHT_RST = 12'd180;

    localparam int DEPTH_RANGE_DEF = 4500;

    // Pipeline shape: four front stages, four divider stages, one output stage
    localparam int N_FRONT    = 4;
    localparam int DIV_STAGES = 4;
    localparam int N_STG      = N_FRONT + DIV_STAGES + 1;
    localparam int Q_W        = 12;     // pixel quotient bits
    localparam int Q_PER      = 3;      // pixel quotient bits per divider stage
    localparam int D_W        = 8;      // depth quotient bits
    localparam int D_PER      = 2;      // depth quotient bits per divider stage
    localparam int REM_W      = 27;     // pixel remainder: below z << 12
    localparam int DREM_W     = 24;     // depth remainder: below 255 * range

    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [23:0] center_x;
        logic [23:0] center_y;
        logic [11:0] image_width;
        logic [11:0] image_height;
    } t_cfg;

    // Word carried through the divider stages
    typedef struct packed {
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
        logic              neg_x;
        logic              neg_y;
        logic              big_x;
        logic              big_y;
        logic [14:0]       z;
        logic              z_pos;
        logic [DREM_W-1:0] rem_d;
        logic [D_W-1:0]    q_d;
        logic              sat;
    } t_div_word;

endpackage

/* rtl/dpp_regs.sv */
// Configuration registers of the projection: intrinsics and image size.
// Depends on dpp_pkg for register codes, reset values and t_cfg.
module dpp_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [23:0]    i_cfg_data,
    output dpp_pkg::t_cfg  o_cfg
);

    dpp_pkg::t_cfg r_cfg;

    // Plain write port; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x      <= dpp_pkg::FOCAL_RST;
            r_cfg.focal_y      <= dpp_pkg::FOCAL_RST;
            r_cfg.center_x     <= dpp_pkg::CENTER_RST;
            r_cfg.center_y     <= dpp_pkg::CENTER_RST;
            r_cfg.image_width  <= dpp_pkg::WIDTH_RST;
            r_cfg.image_height <= dpp_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpp_pkg::REG_FOCAL_X:      r_cfg.focal_x      <= i_cfg_data;
                dpp_pkg::REG_FOCAL_Y:      r_cfg.focal_y      <= i_cfg_data;
                dpp_pkg::REG_CENTER_X:     r_cfg.center_x     <= i_cfg_data;
                dpp_pkg::REG_CENTER_Y:     r_cfg.center_y     <= i_cfg_data;
                dpp_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[11:0];
                dpp_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/dpp_front.sv */
// Front stages: products, numerator sums, magnitudes and range checks.
// Depends on dpp_pkg; feeds the first divider stage with a t_div_word.
module dpp_front #(
    parameter int DEPTH_RANGE_MM = dpp_pkg::DEPTH_RANGE_DEF
) (
    input  logic                          i_clk,
    input  logic [dpp_pkg::N_FRONT-1:0]   i_en,
    input  dpp_pkg::t_cfg                 i_cfg,
    input  logic signed [15:0]            i_point_x,
    input  logic signed [15:0]            i_point_y,
    input  logic signed [15:0]            i_point_z,
    output dpp_pkg::t_div_word            o_word
);

    localparam logic [23:0] RANGE_M1 = 24'(DEPTH_RANGE_MM - 1);
    localparam logic [23:0] SAT_LIM  = 24'(255 * DEPTH_RANGE_MM);

    // stage 1: products
    logic signed [40:0] r_pfx, r_pfy;
    logic [38:0]        r_pcx, r_pcy;
    logic [14:0]        r_z1;
    logic               r_zpos1;
    logic [23:0]        r_da1;
    // stage 2: numerators
    logic signed [41:0] r_nx, r_ny;
    logic [14:0]        r_z2;
    logic               r_zpos2;
    logic [23:0]        r_da2;
    // stage 3: magnitudes scaled down by 256
    logic [32:0]        r_mx, r_my;
    logic               r_negx, r_negy;
    logic [14:0]        r_z3;
    logic               r_zpos3;
    logic [23:0]        r_da3;
    logic               r_sat3;
    // stage 4: overflow flags, divider entry word
    dpp_pkg::t_div_word r_word;

    logic [22:0] z255;
    logic [41:0] ax, ay;
    logic [26:0] zsh;

    assign z255 = {i_point_z[14:0], 8'b0} - {8'b0, i_point_z[14:0]};
    assign ax   = r_nx[41] ? 42'(-r_nx) : 42'(r_nx);
    assign ay   = r_ny[41] ? 42'(-r_ny) : 42'(r_ny);
    assign zsh  = {r_z3, 12'b0};

    // stage 1: four products and the depth numerator z*255 + range-1
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pfx   <= $signed({1'b0, i_cfg.focal_x}) * i_point_x;
            r_pfy   <= $signed({1'b0, i_cfg.focal_y}) * i_point_y;
            r_pcx   <= i_cfg.center_x * i_point_z[14:0];
            r_pcy   <= i_cfg.center_y * i_point_z[14:0];
            r_z1    <= i_point_z[14:0];
            r_zpos1 <= !i_point_z[15] && (i_point_z != 16'sd0);
            r_da1   <= {1'b0, z255} + RANGE_M1;
        end
    end

    // stage 2: f*p + c*z
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_nx    <= $signed({r_pfx[40], r_pfx}) + $signed({3'b000, r_pcx});
            r_ny    <= $signed({r_pfy[40], r_pfy}) + $signed({3'b000, r_pcy});
            r_z2    <= r_z1;
            r_zpos2 <= r_zpos1;
            r_da2   <= r_da1;
        end
    end

    // stage 3: |num| >> 8, since trunc(|num|/(256z)) = floor(floor(|num|/256)/z)
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_mx    <= ax[40:8];
            r_my    <= ay[40:8];
            r_negx  <= r_nx[41];
            r_negy  <= r_ny[41];
            r_z3    <= r_z2;
            r_zpos3 <= r_zpos2;
            r_da3   <= r_da2;
            r_sat3  <= (r_da2 >= SAT_LIM);
        end
    end

    // stage 4: quotient of 4096 or more is off any image
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_word.rem_x <= r_mx[dpp_pkg::REM_W-1:0];
            r_word.rem_y <= r_my[dpp_pkg::REM_W-1:0];
            r_word.q_x   <= '0;
            r_word.q_y   <= '0;
            r_word.neg_x <= r_negx;
            r_word.neg_y <= r_negy;
            r_word.big_x <= (r_mx >= {6'b0, zsh});
            r_word.big_y <= (r_my >= {6'b0, zsh});
            r_word.z     <= r_z3;
            r_word.z_pos <= r_zpos3;
            r_word.rem_d <= r_da3;
            r_word.q_d   <= '0;
            r_word.sat   <= r_sat3;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/dpp_div_stage.sv */
// One stage of the restoring dividers: three pixel quotient bits, two depth bits.
// Depends on dpp_pkg; instantiated DIV_STAGES times by the top level.
module dpp_div_stage #(
    parameter int STAGE          = 0,
    parameter int DEPTH_RANGE_MM = dpp_pkg::DEPTH_RANGE_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  dpp_pkg::t_div_word  i_word,
    output dpp_pkg::t_div_word  o_word
);

    localparam int QB = dpp_pkg::Q_W - 1 - STAGE * dpp_pkg::Q_PER;
    localparam int DB = dpp_pkg::D_W - 1 - STAGE * dpp_pkg::D_PER;
    localparam logic [dpp_pkg::DREM_W-1:0] RANGE = dpp_pkg::DREM_W'(DEPTH_RANGE_MM);

    dpp_pkg::t_div_word r_word;
    dpp_pkg::t_div_word n_word;

    // compare and subtract, most significant quotient bit first
    always_comb begin
        logic [dpp_pkg::REM_W-1:0]  zx;
        logic [dpp_pkg::DREM_W-1:0] dv;
        n_word = i_word;
        for (int j = 0; j < dpp_pkg::Q_PER; j++) begin
            zx = {12'b0, i_word.z} << (QB - j);
            if (n_word.rem_x >= zx) begin
                n_word.rem_x       = n_word.rem_x - zx;
                n_word.q_x[QB - j] = 1'b1;
            end
            if (n_word.rem_y >= zx) begin
                n_word.rem_y       = n_word.rem_y - zx;
                n_word.q_y[QB - j] = 1'b1;
            end
        end
        for (int j = 0; j < dpp_pkg::D_PER; j++) begin
            dv = RANGE << (DB - j);
            if (n_word.rem_d >= dv) begin
                n_word.rem_d       = n_word.rem_d - dv;
                n_word.q_d[DB - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/depth_point_projection.sv */
// Top level of the pinhole depth point projection: handshake, pipeline control, output stage.
// Depends on dpp_pkg, dpp_regs, dpp_front and dpp_div_stage.
//
//   channel   | valid        | ready        | word
//   ----------+--------------+--------------+------------------------------------------
//   point in  | i_in_valid   | o_in_ready   | i_point_x, i_point_y, i_point_z
//   pixel out | o_out_valid  | i_out_ready  | o_pixel_col, o_pixel_row, o_depth_level,
//             |              |              | o_in_view
//   config    | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// One word in and one word out per cycle while the output is not stalled; the word passes
// nine registers on its way: four front stages, four divider stages and the output
// register.
// Each stage holds only when it is full and the stage after it holds, so bubbles are
// squeezed out and an output stall reaches o_in_ready only once every stage is full.
// Synchronous active-low reset clears the valid bits and the configuration registers.
module depth_point_projection #(
    parameter int DEPTH_RANGE_MM = dpp_pkg::DEPTH_RANGE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_point_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [11:0]        o_pixel_col,
    output logic [11:0]        o_pixel_row,
    output logic [7:0]         o_depth_level,
    output logic               o_in_view
);

    localparam int NS = dpp_pkg::N_STG;
    localparam int NF = dpp_pkg::N_FRONT;
    localparam int ND = dpp_pkg::DIV_STAGES;

    dpp_pkg::t_cfg      cfg;
    dpp_pkg::t_div_word div_w [ND+1];
    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      en;

    logic [11:0] r_col, r_row;
    logic [7:0]  r_level;
    logic        r_view;

    logic        col_ok, row_ok, view;
    logic [7:0]  level;

    dpp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Stage enables: a stage moves when it is empty or the next one moves
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    dpp_front #(
        .DEPTH_RANGE_MM (DEPTH_RANGE_MM)
    ) u_front (
        .i_clk     (i_clk),
        .i_en      (en[NF-1:0]),
        .i_cfg     (cfg),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_word    (div_w[0])
    );

    for (genvar s = 0; s < ND; s++) begin : g_div
        dpp_div_stage #(
            .STAGE          (s),
            .DEPTH_RANGE_MM (DEPTH_RANGE_MM)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en[NF+s]),
            .i_word (div_w[s]),
            .o_word (div_w[s+1])
        );
    end

    // Bound checks: a negative numerator is in view only if it truncates to zero
    assign col_ok = !div_w[ND].big_x && (div_w[ND].q_x < cfg.image_width)
                    && (!div_w[ND].neg_x || (div_w[ND].q_x == '0));
    assign row_ok = !div_w[ND].big_y && (div_w[ND].q_y < cfg.image_height)
                    && (!div_w[ND].neg_y || (div_w[ND].q_y == '0));
    assign view   = div_w[ND].z_pos && col_ok && row_ok;
    assign level  = (!div_w[ND].z_pos || div_w[ND].sat) ? 8'd0 : 8'(8'd255 - div_w[ND].q_d);

    // Output register
    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_col   <= view ? div_w[ND].q_x : 12'd0;
            r_row   <= view ? div_w[ND].q_y : 12'd0;
            r_level <= level;
            r_view  <= view;
        end
    end

    assign o_in_ready    = en[0];
    assign o_out_valid   = r_vld[NS-1];
    assign o_pixel_col   = r_col;
    assign o_pixel_row   = r_row;
    assign o_depth_level = r_level;
    assign o_in_view     = r_view;

endmodule

/* rtl/dpp_checker.sv */
// Port-level checks for depth_point_projection, attached by the bind at the end.
// Depends only on the top level's ports.
module dpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_pixel_col,
    input logic [11:0] o_pixel_row,
    input logic [7:0]  o_depth_level,
    input logic        o_in_view
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_col)
            && $stable(o_pixel_row) && $stable(o_depth_level) && $stable(o_in_view))
        else $error("result word changed under stall");

    // nothing comes out the cycle after a reset edge
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // input back-pressure only when the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused while output is free");

    // an offered point word stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid)
        else $error("point word withdrawn before acceptance");

    // off-image results carry a zero pixel
    a_zero_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_view |-> o_pixel_col == 12'd0 && o_pixel_row == 12'd0)
        else $error("pixel not zero when out of view");

endmodule

bind depth_point_projection dpp_checker u_dpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_col   (o_pixel_col),
    .o_pixel_row   (o_pixel_row),
    .o_depth_level (o_depth_level),
    .o_in_view     (o_in_view)
);

/* bench/depth_point_projection_checker.sv */
// Checker for depth_point_projection: watches the register port and both word channels,
// predicts each result word and compares it with what leaves the block.
// Depends on dpp_pkg.
`timescale 1ns / 100ps

module depth_point_projection_checker #(
    parameter int DEPTH_RANGE_MM = dpp_pkg::DEPTH_RANGE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_point_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [11:0]        i_pixel_col,
    input  logic [11:0]        i_pixel_row,
    input  logic [7:0]         i_depth_level,
    input  logic               i_in_view,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_seen_in_view
);

    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  level;
        logic        view;
    } t_pixel_word;

    // Expected word together with the point that caused it, for reporting
    typedef struct {
        t_pixel_word       pix;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_projected_point;

    // Own copy of the camera registers
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic [23:0] center_x;
    logic [23:0] center_y;
    logic [11:0] image_width;
    logic [11:0] image_height;

    t_projected_point expected_pixels[$];

    // Exact pinhole projection: truncation toward zero, depth level by ceiling
    function automatic t_pixel_word project_point(input logic signed [15:0] px,
                                                  input logic signed [15:0] py,
                                                  input logic signed [15:0] pz);
        longint x, y, z, den, col, row, scaled;
        t_pixel_word w;
        w = '0;
        x = px;
        y = py;
        z = pz;
        if (z > 0) begin
            den = z * 256;
            col = (longint'(focal_x) * x + longint'(center_x) * z) / den;
            row = (longint'(focal_y) * y + longint'(center_y) * z) / den;
            scaled = (z * 255 + DEPTH_RANGE_MM - 1) / DEPTH_RANGE_MM;
            w.level = (scaled >= 255) ? 8'd0 : 8'(255 - scaled);
            if (col >= 0 && col < longint'(image_width) &&
                row >= 0 && row < longint'(image_height)) begin
                w.col  = col[11:0];
                w.row  = row[11:0];
                w.view = 1'b1;
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_projected_point item;
        t_projected_point head;
        t_pixel_word got;
        if (!i_rst_n) begin
            focal_x      = dpp_pkg::FOCAL_RST;
            focal_y      = dpp_pkg::FOCAL_RST;
            center_x     = dpp_pkg::CENTER_RST;
            center_y     = dpp_pkg::CENTER_RST;
            image_width  = dpp_pkg::WIDTH_RST;
            image_height = dpp_pkg::HEIGHT_RST;
            expected_pixels.delete();
        end else begin
            // Result word leaving the block
            if (i_out_valid && i_out_ready) begin
                got = {i_pixel_col, i_pixel_row, i_depth_level, i_in_view};
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected word col %0d row %0d level %0d view %0d",
                                 $time, got.col, got.row, got.level, got.view);
                end else begin
                    head = expected_pixels.pop_front();
                    o_checked++;
                    if (got.view === 1'b1)
                        o_seen_in_view++;
                    if (got !== head.pix) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("%0t: point (%0d,%0d,%0d)",
                                     $time, head.x, head.y, head.z);
                            $display("  expected col %0d row %0d level %0d view %0d",
                                     head.pix.col, head.pix.row, head.pix.level,
                                     head.pix.view);
                            $display("  got      col %0d row %0d level %0d view %0d",
                                     got.col, got.row, got.level, got.view);
                        end
                    end
                end
            end
            // Point word entering the block
            if (i_in_valid && i_in_ready) begin
                item.pix = project_point(i_point_x, i_point_y, i_point_z);
                item.x   = i_point_x;
                item.y   = i_point_y;
                item.z   = i_point_z;
                expected_pixels.push_back(item);
            end
            // Register writes; unknown indexes leave everything alone
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dpp_pkg::REG_FOCAL_X:      focal_x      = i_cfg_data;
                    dpp_pkg::REG_FOCAL_Y:      focal_y      = i_cfg_data;
                    dpp_pkg::REG_CENTER_X:     center_x     = i_cfg_data;
                    dpp_pkg::REG_CENTER_Y:     center_y     = i_cfg_data;
                    dpp_pkg::REG_IMAGE_WIDTH:  image_width  = i_cfg_data[11:0];
                    dpp_pkg::REG_IMAGE_HEIGHT: image_height = i_cfg_data[11:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

/* bench/depth_point_projection_tb.sv */
// Testbench top for depth_point_projection: clock, reset, register settings, point stimulus
// with idling phases and verdict. Needs dpp_pkg, the DUT and depth_point_projection_checker.
`timescale 1ns / 100ps

module depth_point_projection_tb;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int N_SETTINGS   = 8;
    localparam int PHASE_POINTS = 64;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_point_x;
    logic signed [15:0] i_point_y;
    logic signed [15:0] i_point_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [11:0]        o_pixel_col;
    logic [11:0]        o_pixel_row;
    logic [7:0]         o_depth_level;
    logic               o_in_view;

    int fail_count;
    int pending;
    int checked;
    int seen_in_view;
    int points_sent;
    int sender_idle_pct;
    int receiver_stall_pct;

    // Camera as last written, used only to aim points near the image
    longint aim_fx, aim_fy, aim_cx, aim_cy, aim_w, aim_h;

    depth_point_projection dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_col  (o_pixel_col),
        .o_pixel_row  (o_pixel_row),
        .o_depth_level(o_depth_level),
        .o_in_view    (o_in_view)
    );

    depth_point_projection_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pixel_col   (o_pixel_col),
        .i_pixel_row   (o_pixel_row),
        .i_depth_level (o_depth_level),
        .i_in_view     (o_in_view),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_seen_in_view(seen_in_view)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit
    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", pending);
        $display("depth_point_projection verification failed");
        $finish;
    end

    // Receiver: stalls at random according to the current phase
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // One register write per cycle; caller lowers the enable afterwards
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            dpp_pkg::REG_FOCAL_X:      aim_fx = val;
            dpp_pkg::REG_FOCAL_Y:      aim_fy = val;
            dpp_pkg::REG_CENTER_X:     aim_cx = val;
            dpp_pkg::REG_CENTER_Y:     aim_cy = val;
            dpp_pkg::REG_IMAGE_WIDTH:  aim_w  = val[11:0];
            dpp_pkg::REG_IMAGE_HEIGHT: aim_h  = val[11:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_camera(input int setting);
        int fpix;
        case (setting)
            0: begin    // VGA-like camera
                write_reg(dpp_pkg::REG_FOCAL_X, 24'd128000);
                write_reg(dpp_pkg::REG_FOCAL_Y, 24'd128000);
                write_reg(dpp_pkg::REG_CENTER_X, 24'd81920);
                write_reg(dpp_pkg::REG_CENTER_Y, 24'd61440);
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'd640);
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'd480);
            end
            1: begin    // everything at its minimum: all points land on pixel 0
                write_reg(dpp_pkg::REG_FOCAL_X, 24'd0);
                write_reg(dpp_pkg::REG_FOCAL_Y, 24'd0);
                write_reg(dpp_pkg::REG_CENTER_X, 24'd0);
                write_reg(dpp_pkg::REG_CENTER_Y, 24'd0);
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'd1);
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'd1);
            end
            2: begin    // everything at its maximum
                write_reg(dpp_pkg::REG_FOCAL_X, 24'hFFFFFF);
                write_reg(dpp_pkg::REG_FOCAL_Y, 24'hFFFFFF);
                write_reg(dpp_pkg::REG_CENTER_X, 24'hFFFFFF);
                write_reg(dpp_pkg::REG_CENTER_Y, 24'hFFFFFF);
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'd4095);
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'd4095);
            end
            3: begin    // zero width, plus writes to unused indexes
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'd0);
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'($urandom_range(1, 4095)));
                write_reg(REG_SPARE_6, 24'($urandom));
                write_reg(REG_SPARE_7, 24'($urandom));
            end
            4: begin    // fully random fields, zero sizes included
                write_reg(dpp_pkg::REG_FOCAL_X, 24'($urandom));
                write_reg(dpp_pkg::REG_FOCAL_Y, 24'($urandom));
                write_reg(dpp_pkg::REG_CENTER_X, 24'($urandom));
                write_reg(dpp_pkg::REG_CENTER_Y, 24'($urandom));
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'($urandom_range(0, 4095)));
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'($urandom_range(0, 4095)));
            end
            5: begin    // plausible random camera
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'($urandom_range(1, 4095)));
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'($urandom_range(1, 4095)));
                fpix = $urandom_range(64 * 256, 2048 * 256);
                write_reg(dpp_pkg::REG_FOCAL_X, 24'(fpix));
                write_reg(dpp_pkg::REG_FOCAL_Y, 24'(fpix + $urandom_range(0, 4095)));
                write_reg(dpp_pkg::REG_CENTER_X, 24'($urandom_range(0, aim_w * 256)));
                write_reg(dpp_pkg::REG_CENTER_Y, 24'($urandom_range(0, aim_h * 256)));
            end
            6: begin    // back to the reset values
                write_reg(dpp_pkg::REG_FOCAL_X, dpp_pkg::FOCAL_RST);
                write_reg(dpp_pkg::REG_FOCAL_Y, dpp_pkg::FOCAL_RST);
                write_reg(dpp_pkg::REG_CENTER_X, dpp_pkg::CENTER_RST);
                write_reg(dpp_pkg::REG_CENTER_Y, dpp_pkg::CENTER_RST);
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'(dpp_pkg::WIDTH_RST));
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'(dpp_pkg::HEIGHT_RST));
            end
            default: begin  // sub-pixel focal lengths, zero height
                write_reg(dpp_pkg::REG_FOCAL_X, 24'($urandom_range(1, 255)));
                write_reg(dpp_pkg::REG_FOCAL_Y, 24'($urandom_range(1, 255)));
                write_reg(dpp_pkg::REG_CENTER_X, 24'($urandom_range(0, 4095 * 256)));
                write_reg(dpp_pkg::REG_IMAGE_WIDTH, 24'(4095));
                write_reg(dpp_pkg::REG_IMAGE_HEIGHT, 24'd0);
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // Offer one point word and hold it until the block takes it
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x  <= x;
        i_point_y  <= y;
        i_point_z  <= z;
        do @(posedge i_clk); while (!o_in_ready);
        points_sent++;
        @(negedge i_clk);
    endtask

    // Coordinate that lands a few pixels around the image along one axis
    function automatic logic signed [15:0] aim_coord(input longint focal, input longint centre,
                                                     input longint span, input longint z);
        longint t, v;
        if (focal == 0)
            return 16'($urandom);
        t = longint'($urandom_range(0, 32'(span + 3))) - 2;
        v = ((t * 256 + longint'($urandom_range(0, 255)) - centre) * z) / focal;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic send_random_point();
        int kind;
        longint z;
        logic signed [15:0] x, y;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: z = $urandom_range(1, 255);
            1: z = $urandom_range(1, 4600);
            2: z = $urandom_range(1, 32767);
            default: z = $urandom_range(4400, 4600);
        endcase
        if (kind < 2) begin
            // raw noise over the whole field range
            send_point(16'($urandom), 16'($urandom), 16'($urandom));
        end else if (kind == 2) begin
            // invalid depth
            z = -longint'($urandom_range(0, 32768));
            send_point(16'($urandom), 16'($urandom), z[15:0]);
        end else begin
            x = aim_coord(aim_fx, aim_cx, aim_w, z);
            y = aim_coord(aim_fy, aim_cy, aim_h, z);
            send_point(x, y, z[15:0]);
        end
    endtask

    // Let every outstanding word drain, then give the pipe its latency
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (dpp_pkg::N_STG + 2) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = dpp_pkg::REG_FOCAL_X;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_point_x          = '0;
        i_point_y          = '0;
        i_point_z          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        points_sent        = 0;
        aim_fx = dpp_pkg::FOCAL_RST;
        aim_fy = dpp_pkg::FOCAL_RST;
        aim_cx = dpp_pkg::CENTER_RST;
        aim_cy = dpp_pkg::CENTER_RST;
        aim_w  = dpp_pkg::WIDTH_RST;
        aim_h  = dpp_pkg::HEIGHT_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed points against the reset camera (256 px focal, 320 x 180)
        send_point(16'sd0, 16'sd0, 16'sd1000);          // on the principal point
        send_point(-16'sd1, -16'sd1, 16'sd1000);        // just below zero, truncates to 0
        send_point(16'sd5, 16'sd5, 16'sd0);             // zero depth
        send_point(16'sd5, 16'sd5, -16'sd1);            // negative depth
        send_point(16'sd0, 16'sd0, -16'sd32768);        // most negative depth
        send_point(16'sd32767, 16'sd32767, 16'sd32767); // column in, row out
        send_point(-16'sd32768, -16'sd32768, 16'sd1);
        send_point(16'sd32767, -16'sd32768, 16'sd1);
        send_point(16'sd0, 16'sd0, 16'sd1);             // nearest depth
        send_point(16'sd0, 16'sd0, 16'sd17);
        send_point(16'sd0, 16'sd0, 16'sd18);            // first step in depth level
        send_point(16'sd0, 16'sd0, 16'sd4482);          // last non-zero level
        send_point(16'sd0, 16'sd0, 16'sd4483);
        send_point(16'sd0, 16'sd0, 16'sd4500);          // depth equal to the range, level 0
        send_point(16'sd0, 16'sd0, 16'sd32767);
        send_point(16'sd1249, 16'sd0, 16'sd1000);       // last column inside
        send_point(16'sd1250, 16'sd0, 16'sd1000);       // column equal to width
        send_point(16'sd0, 16'sd703, 16'sd1000);        // last row inside
        send_point(16'sd0, 16'sd704, 16'sd1000);        // row equal to height
        send_point(-16'sd4, 16'sd0, 16'sd1000);         // column truncates to -1
        send_point(16'sd0, -16'sd4, 16'sd1000);

        // Random phases: each a new camera and one of four idling modes
        for (int setting = 0; setting < N_SETTINGS; setting++) begin
            wait_idle();
            set_camera(setting);
            case (setting % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
                default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
            endcase
            for (int n = 0; n < PHASE_POINTS; n++)
                send_random_point();
        end

        wait_idle();
        $display("sent %0d points under %0d camera settings and four idling modes",
                 points_sent, N_SETTINGS + 1);
        $display("checked %0d result words, %0d of them in view", checked, seen_in_view);
        if (fail_count == 0 && pending == 0) begin
            $display("depth_point_projection verification clean");
        end else begin
            $display("depth_point_projection verification failed");
        end
        $finish;
    end

endmodule

/* depth_point_projection.f */
rtl/dpp_pkg.sv
rtl/dpp_regs.sv
rtl/dpp_front.sv
rtl/dpp_div_stage.sv
rtl/depth_point_projection.sv
rtl/dpp_checker.sv
bench/depth_point_projection_checker.sv
bench/depth_point_projection_tb.sv
